>>> hdl/cpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_pkg
// Types, constants and tables shared by the caption pair decoder
// ----------------------------------------------------------------------------
package cpd_pkg;

   localparam int ROWS_DEF      = 15;
   localparam int COLUMNS_DEF   = 32;
   localparam int XDS_LIMIT_DEF = 33;

   localparam int ADDR_W = 10;
   localparam int CELL_W = 12;

   localparam logic [6:0] SPACE_CODE  = 7'h20;
   localparam logic [4:0] ATTR_ITALIC = 5'h08;
   localparam logic [4:0] ATTR_UNDER  = 5'h10;

   localparam logic [1:0] ACT_PAIR        = 2'd0;
   localparam logic [1:0] ACT_READ_SHOWN  = 2'd1;
   localparam logic [1:0] ACT_READ_HIDDEN = 2'd2;

   localparam logic [6:0] MISC_RCL = 7'h20;
   localparam logic [6:0] MISC_BS  = 7'h21;
   localparam logic [6:0] MISC_DER = 7'h24;
   localparam logic [6:0] MISC_RU2 = 7'h25;
   localparam logic [6:0] MISC_RU3 = 7'h26;
   localparam logic [6:0] MISC_RU4 = 7'h27;
   localparam logic [6:0] MISC_RDC = 7'h29;
   localparam logic [6:0] MISC_TR  = 7'h2A;
   localparam logic [6:0] MISC_EDM = 7'h2C;
   localparam logic [6:0] MISC_CR  = 7'h2D;
   localparam logic [6:0] MISC_ENM = 7'h2E;
   localparam logic [6:0] MISC_EOC = 7'h2F;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [3:0] cell_row;
      logic [4:0] cell_col;
   } req_type;

   typedef struct packed {
      logic        display_changed;
      logic [3:0]  cursor_row;
      logic [4:0]  cursor_col;
      logic [4:0]  attributes_now;
      logic        loading_hidden;
      logic [3:0]  roll_depth;
      logic        xds_busy;
      logic [15:0] cell_unicode;
      logic [4:0]  cell_attributes;
   } rsp_type;

   typedef enum logic [3:0] {
      KIND_NOP, KIND_READ, KIND_XDS, KIND_PRINT, KIND_PAC,
      KIND_MIDROW, KIND_MISC, KIND_TAB, KIND_IGNORE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] b1;
      logic [6:0] b2;
      logic       read_hidden;
      logic       read_ok;
      logic [3:0] row;
      logic [4:0] col;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_PUT2, ST_READ, ST_SWEEP, ST_CR_RD, ST_CR_WR, ST_RESP
   } back_state_type;

   function automatic logic [3:0] pac_row(input logic [2:0] code);
      logic [3:0] r;
      case (code)
         3'd0:    r = 4'd10;
         3'd1:    r = 4'd0;
         3'd2:    r = 4'd2;
         3'd3:    r = 4'd11;
         3'd4:    r = 4'd13;
         3'd5:    r = 4'd4;
         3'd6:    r = 4'd6;
         default: r = 4'd8;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] to_unicode(input logic [6:0] code);
      logic [15:0] u;
      case (code)
         7'h2A:   u = 16'h00E1;
         7'h5C:   u = 16'h00E9;
         7'h5E:   u = 16'h00ED;
         7'h5F:   u = 16'h00F3;
         7'h60:   u = 16'h00FA;
         7'h7B:   u = 16'h00E7;
         7'h7C:   u = 16'h00F7;
         7'h7D:   u = 16'h00D1;
         7'h7E:   u = 16'h00F1;
         7'h7F:   u = 16'h25A0;
         default: u = {9'd0, code};
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

>>> hdl/cpd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_front
// Classifies each incoming transaction into a decoder command
// ----------------------------------------------------------------------------
module cpd_front import cpd_pkg::*; #(
   parameter int ROWS    = ROWS_DEF,
   parameter int COLUMNS = COLUMNS_DEF
) (
   input  req_type req,
   output cmd_type cmd
);

   logic [6:0] b1;
   logic [6:0] b2;
   logic [6:0] c1;

   assign b1 = req.first_byte[6:0];
   assign b2 = req.second_byte[6:0];
   assign c1 = b1 & ~7'h08;

   always_comb begin
      cmd.kind        = KIND_IGNORE;
      cmd.b1          = b1;
      cmd.b2          = b2;
      cmd.read_hidden = (req.action == ACT_READ_HIDDEN);
      cmd.read_ok     = (32'(req.cell_row) < ROWS) && (32'(req.cell_col) < COLUMNS);
      cmd.row         = req.cell_row;
      cmd.col         = req.cell_col;
      case (req.action)
         ACT_PAIR: begin
            if (b1 inside {[7'h01:7'h0F]}) begin
               cmd.kind = KIND_XDS;
            end else if (b1 >= 7'h20) begin
               cmd.kind = KIND_PRINT;
            end else if ((c1 inside {[7'h10:7'h17]}) && b2 >= 7'h40) begin
               cmd.kind = KIND_PAC;
            end else if (c1 == 7'h11 && (b2 inside {[7'h20:7'h2F]})) begin
               cmd.kind = KIND_MIDROW;
            end else if (c1 == 7'h14) begin
               cmd.kind = KIND_MISC;
            end else if (c1 == 7'h17 && (b2 inside {[7'h21:7'h23]})) begin
               cmd.kind = KIND_TAB;
            end
         end
         ACT_READ_SHOWN, ACT_READ_HIDDEN: begin
            cmd.kind = KIND_READ;
         end
         default: begin
            cmd.kind = KIND_NOP;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/cpd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_queue
// Two-entry command queue between front and back
// ----------------------------------------------------------------------------
module cpd_queue import cpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    valid,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/cpd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_back
// Executes decoder commands against the caption memories and cursor state
// ----------------------------------------------------------------------------
module cpd_back import cpd_pkg::*; #(
   parameter int ROWS      = ROWS_DEF,
   parameter int COLUMNS   = COLUMNS_DEF,
   parameter int XDS_LIMIT = XDS_LIMIT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    clearing,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam logic [3:0] LAST_ROW = 4'(ROWS - 1);
   localparam logic [4:0] LAST_COL = 5'(COLUMNS - 1);

   back_state_type state_ff, state_in;
   logic        shown_ff, shown_in;
   logic [3:0]  row_ff, row_in;
   logic [4:0]  col_ff, col_in;
   logic [4:0]  attr_ff, attr_in;
   logic        hidden_ff, hidden_in;
   logic [3:0]  roll_ff, roll_in;
   logic        xflag_ff, xflag_in;
   logic [5:0]  xcount_ff, xcount_in;
   logic        changed_ff, changed_in;
   logic [15:0] uni_ff, uni_in;
   logic [4:0]  cattr_ff, cattr_in;
   cmd_type     cmd_ff, cmd_in;
   logic        sw_mem_ff, sw_mem_in;
   logic [3:0]  sw_row_ff, sw_row_in;
   logic [4:0]  sw_col_ff, sw_col_in;
   logic [3:0]  sw_last_ff, sw_last_in;
   logic        sw_both_ff, sw_both_in;
   logic [3:0]  cr_row_ff, cr_row_in;
   logic [4:0]  cr_col_ff, cr_col_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [CELL_W-1:0] ram [2**ADDR_W];
   logic [CELL_W-1:0] rdata_ff;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [CELL_W-1:0] wdata;
   logic [ADDR_W-1:0] raddr;

   logic       load_mem;
   logic [4:0] put_col;
   logic [4:0] pac_sum;
   logic [5:0] tab_sum;
   logic [5:0] xds_next;
   logic [4:0] row_plus;
   logic [4:0] top_wide;
   logic [3:0] cr_top;
   logic [3:0] roll_new;
   logic [4:0] bs_col;

   assign load_mem = shown_ff ^ hidden_ff;
   assign put_col  = (col_ff >= LAST_COL) ? LAST_COL - 5'd1 : col_ff;
   assign pac_sum  = {1'b0, pac_row(q_head.b1[2:0])} + {4'd0, q_head.b2[5]};
   assign tab_sum  = {1'b0, col_ff} + {4'd0, q_head.b2[1:0]};
   assign xds_next = xcount_ff + 6'd1;
   assign row_plus = {1'b0, row_ff} + 5'd1;
   assign top_wide = (row_plus > {1'b0, roll_ff}) ? row_plus - {1'b0, roll_ff} : 5'd0;
   assign cr_top   = top_wide[3:0];
   assign roll_new = {2'd0, q_head.b2[1:0]} + 4'd1;
   assign bs_col   = (col_ff == 5'd0) ? 5'd0 : col_ff - 5'd1;

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram[waddr] <= wdata;
      end
      rdata_ff <= ram[raddr];
   end

   always_comb begin
      state_in     = state_ff;
      shown_in     = shown_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      attr_in      = attr_ff;
      hidden_in    = hidden_ff;
      roll_in      = roll_ff;
      xflag_in     = xflag_ff;
      xcount_in    = xcount_ff;
      changed_in   = changed_ff;
      uni_in       = uni_ff;
      cattr_in     = cattr_ff;
      cmd_in       = cmd_ff;
      sw_mem_in    = sw_mem_ff;
      sw_row_in    = sw_row_ff;
      sw_col_in    = sw_col_ff;
      sw_last_in   = sw_last_ff;
      sw_both_in   = sw_both_ff;
      cr_row_in    = cr_row_ff;
      cr_col_in    = cr_col_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = '0;
      wdata        = {5'd0, SPACE_CODE};
      raddr        = {q_head.read_hidden ^ shown_ff, q_head.row, q_head.col};

      case (state_ff)
         ST_CLEAR, ST_SWEEP: begin
            we    = 1'b1;
            waddr = {sw_mem_ff, sw_row_ff, sw_col_ff};
            if (sw_col_ff == LAST_COL) begin
               sw_col_in = 5'd0;
               if (sw_row_ff == sw_last_ff) begin
                  if (sw_both_ff) begin
                     sw_both_in = 1'b0;
                     sw_mem_in  = 1'b1;
                     sw_row_in  = 4'd0;
                  end else begin
                     state_in = (state_ff == ST_CLEAR) ? ST_IDLE : ST_RESP;
                  end
               end else begin
                  sw_row_in = sw_row_ff + 4'd1;
               end
            end else begin
               sw_col_in = sw_col_ff + 5'd1;
            end
         end

         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cmd_in     = q_head;
               changed_in = 1'b0;
               uni_in     = 16'd0;
               cattr_in   = 5'd0;
               state_in   = ST_RESP;
               if (q_head.kind != KIND_NOP && q_head.kind != KIND_READ &&
                   (xflag_ff || q_head.kind == KIND_XDS)) begin
                  if (q_head.b1 == 7'h0F || 32'(xds_next) >= XDS_LIMIT) begin
                     xflag_in  = 1'b0;
                     xcount_in = 6'd0;
                  end else begin
                     xflag_in  = 1'b1;
                     xcount_in = xds_next;
                  end
               end else begin
                  case (q_head.kind)
                     KIND_READ: begin
                        state_in = ST_READ;
                     end
                     KIND_PRINT: begin
                        we         = 1'b1;
                        waddr      = {load_mem, row_ff, put_col};
                        wdata      = {attr_ff, q_head.b1};
                        col_in     = put_col + 5'd1;
                        changed_in = 1'b1;
                        if (q_head.b2 >= 7'h20) begin
                           state_in = ST_PUT2;
                        end
                     end
                     KIND_PAC: begin
                        row_in = (pac_sum > {1'b0, LAST_ROW}) ? LAST_ROW : pac_sum[3:0];
                        if (q_head.b2[4]) begin
                           col_in = ({q_head.b2[3:1], 2'b00} > LAST_COL) ?
                                    LAST_COL : {q_head.b2[3:1], 2'b00};
                           attr_in = q_head.b2[0] ? ATTR_UNDER : 5'd0;
                        end else if (q_head.b2[3:1] == 3'd7) begin
                           attr_in = ATTR_ITALIC | (q_head.b2[0] ? ATTR_UNDER : 5'd0);
                        end else begin
                           attr_in = {q_head.b2[0], 1'b0, q_head.b2[3:1]};
                        end
                     end
                     KIND_MIDROW: begin
                        if (q_head.b2[3:1] == 3'd7) begin
                           attr_in = attr_ff | ATTR_ITALIC |
                                     (q_head.b2[0] ? ATTR_UNDER : 5'd0);
                        end else begin
                           attr_in = {q_head.b2[0], 1'b0, q_head.b2[3:1]};
                        end
                     end
                     KIND_TAB: begin
                        col_in = (tab_sum > {1'b0, LAST_COL}) ? LAST_COL : tab_sum[4:0];
                     end
                     KIND_MISC: begin
                        case (q_head.b2)
                           MISC_RCL: begin
                              hidden_in = 1'b1;
                           end
                           MISC_BS: begin
                              col_in     = bs_col;
                              we         = 1'b1;
                              waddr      = {load_mem, row_ff, bs_col};
                              changed_in = ~hidden_ff;
                           end
                           MISC_DER: begin
                              sw_mem_in  = load_mem;
                              sw_row_in  = row_ff;
                              sw_col_in  = col_ff;
                              sw_last_in = row_ff;
                              sw_both_in = 1'b0;
                              state_in   = ST_SWEEP;
                              changed_in = ~hidden_ff;
                           end
                           MISC_RU2, MISC_RU3, MISC_RU4: begin
                              roll_in   = roll_new;
                              hidden_in = 1'b0;
                              if (roll_new > row_ff) begin
                                 row_in = LAST_ROW;
                              end
                           end
                           MISC_RDC: begin
                              hidden_in = 1'b0;
                           end
                           MISC_TR: begin
                              hidden_in = 1'b0;
                              roll_in   = 4'(ROWS);
                              row_in    = LAST_ROW;
                              attr_in   = 5'd0;
                           end
                           MISC_EDM: begin
                              sw_mem_in  = shown_ff;
                              sw_row_in  = 4'd0;
                              sw_col_in  = 5'd0;
                              sw_last_in = LAST_ROW;
                              sw_both_in = 1'b0;
                              state_in   = ST_SWEEP;
                              changed_in = 1'b1;
                           end
                           MISC_CR: begin
                              changed_in = 1'b1;
                              col_in     = 5'd0;
                              if (cr_top < row_ff) begin
                                 cr_row_in = cr_top + 4'd1;
                                 cr_col_in = 5'd0;
                                 state_in  = ST_CR_RD;
                              end else begin
                                 sw_mem_in  = shown_ff;
                                 sw_row_in  = row_ff;
                                 sw_col_in  = 5'd0;
                                 sw_last_in = row_ff;
                                 sw_both_in = 1'b0;
                                 state_in   = ST_SWEEP;
                              end
                           end
                           MISC_ENM: begin
                              sw_mem_in  = ~shown_ff;
                              sw_row_in  = 4'd0;
                              sw_col_in  = 5'd0;
                              sw_last_in = LAST_ROW;
                              sw_both_in = 1'b0;
                              state_in   = ST_SWEEP;
                           end
                           MISC_EOC: begin
                              shown_in   = ~shown_ff;
                              changed_in = 1'b1;
                           end
                           default: begin
                              state_in = ST_RESP;
                           end
                        endcase
                     end
                     default: begin
                        state_in = ST_RESP;
                     end
                  endcase
               end
            end
         end

         ST_PUT2: begin
            we       = 1'b1;
            waddr    = {load_mem, row_ff, put_col};
            wdata    = {attr_ff, cmd_ff.b2};
            col_in   = put_col + 5'd1;
            state_in = ST_RESP;
         end

         ST_READ: begin
            if (cmd_ff.read_ok) begin
               uni_in   = to_unicode(rdata_ff[6:0]);
               cattr_in = rdata_ff[11:7];
            end
            state_in = ST_RESP;
         end

         ST_CR_RD: begin
            raddr    = {shown_ff, cr_row_ff, cr_col_ff};
            state_in = ST_CR_WR;
         end

         ST_CR_WR: begin
            we       = 1'b1;
            waddr    = {shown_ff, cr_row_ff - 4'd1, cr_col_ff};
            wdata    = rdata_ff;
            state_in = ST_CR_RD;
            if (cr_col_ff == LAST_COL) begin
               cr_col_in = 5'd0;
               if (cr_row_ff == row_ff) begin
                  sw_mem_in  = shown_ff;
                  sw_row_in  = row_ff;
                  sw_col_in  = 5'd0;
                  sw_last_in = row_ff;
                  sw_both_in = 1'b0;
                  state_in   = ST_SWEEP;
               end else begin
                  cr_row_in = cr_row_ff + 4'd1;
               end
            end else begin
               cr_col_in = cr_col_ff + 5'd1;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.display_changed = changed_ff;
               rsp_in.cursor_row      = row_ff;
               rsp_in.cursor_col      = col_ff;
               rsp_in.attributes_now  = attr_ff;
               rsp_in.loading_hidden  = hidden_ff;
               rsp_in.roll_depth      = roll_ff;
               rsp_in.xds_busy        = xflag_ff;
               rsp_in.cell_unicode    = uni_ff;
               rsp_in.cell_attributes = cattr_ff;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      changed_ff <= changed_in;
      uni_ff     <= uni_in;
      cattr_ff   <= cattr_in;
      cmd_ff     <= cmd_in;
      cr_row_ff  <= cr_row_in;
      cr_col_ff  <= cr_col_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         shown_ff     <= 1'b0;
         row_ff       <= 4'd0;
         col_ff       <= 5'd0;
         attr_ff      <= 5'd0;
         hidden_ff    <= 1'b0;
         roll_ff      <= 4'd1;
         xflag_ff     <= 1'b0;
         xcount_ff    <= 6'd0;
         sw_mem_ff    <= 1'b0;
         sw_row_ff    <= 4'd0;
         sw_col_ff    <= 5'd0;
         sw_last_ff   <= LAST_ROW;
         sw_both_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shown_ff     <= shown_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         hidden_ff    <= hidden_in;
         roll_ff      <= roll_in;
         xflag_ff     <= xflag_in;
         xcount_ff    <= xcount_in;
         sw_mem_ff    <= sw_mem_in;
         sw_row_ff    <= sw_row_in;
         sw_col_ff    <= sw_col_in;
         sw_last_ff   <= sw_last_in;
         sw_both_ff   <= sw_both_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/caption_pair_decoder.sv
// most pairs pass through the idle and response states; reads add a read
// state, two-character pairs a second write state; erase commands sweep a whole
// memory, delete to end of row from the cursor to the row end; carriage return
// copies each moved row up cell by cell, a read state then a write state per
// cell, then blanks the cursor row; one transaction in the back end at a time
// after reset a clearing pass blanks both memories while req_stall is held high
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// caption_pair_decoder
// Line-21 caption pair decoder with displayed and non-displayed memories
// ----------------------------------------------------------------------------
module caption_pair_decoder import cpd_pkg::*; #(
   parameter int ROWS            = ROWS_DEF,
   parameter int COLUMNS         = COLUMNS_DEF,
   parameter int XDS_LIMIT_PAIRS = XDS_LIMIT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type front_cmd;
   cmd_type q_head;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_valid;
   logic    clearing;

   assign req_stall = q_full || clearing;
   assign q_push    = req_valid && !req_stall;

   cpd_front #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   cpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   cpd_back #(
      .ROWS      (ROWS),
      .COLUMNS   (COLUMNS),
      .XDS_LIMIT (XDS_LIMIT_PAIRS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.cursor_row) < ROWS) && (32'(rsp_data.cursor_col) < COLUMNS))
      else $error("cursor outside caption area");

   a_roll_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.roll_depth != 4'd0)
      else $error("roll-up depth zero");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
